@@ hdl/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants, types and functions for the AES block encryptor.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int RK_DEPTH = 60;
  localparam int RK_AW    = $clog2(RK_DEPTH);

  // configuration register indexes
  localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [2:0] REG_KEY_WORD_A = 3'd1;
  localparam logic [2:0] REG_KEY_WORD_B = 3'd2;
  localparam logic [2:0] REG_KEY_WORD_C = 3'd3;
  localparam logic [2:0] REG_KEY_WORD_D = 3'd4;

  localparam logic [7:0] RCON_FIRST = 8'h01;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_INIT,
    ST_ROUND,
    ST_OUT
  } state_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tbl[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

@@ hdl/aes_ram.sv @@
// ----------------------------------------------------------------------------
// aes_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/aes_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// aes_block_encrypt
// AES-128/192/256 ECB block encryptor with a memory-held round-key schedule.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*   : register writes (index 0 key_length, 1..4 key words a..d).
//             Every write re-expands the key into the round-key RAM, one
//             32-bit word per cycle (44, 52 or 60 words); cfg_ready
//             and s_tready stay low meanwhile.
//   s_axis  : one plaintext block per transaction; s_tready is held low while
//             a register write is offered, so the write goes first.
//   m_axis  : one ciphertext block per plaintext block.
// Each round key word is read from the RAM's registered read port, and
// the shared round unit adds the key words column by column, applying
// the round function at each round's first column; one block at a time.
// The result sits in an output register until m_tready; the next block is
// taken only after it leaves.
// Reset (rst, synchronous) clears key registers and control; the round-key
// RAM holds garbage until the first configuration write.
// ----------------------------------------------------------------------------
module aes_block_encrypt (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // plain_high [63:0], plain_low [127:64]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // cipher_high [63:0], cipher_low [127:64]
);
  import aes_pkg::*;

  state_t state, state_next;

  logic [1:0]  key_length;
  logic [63:0] key_a, key_b, key_c, key_d;

  logic [RK_AW-1:0] widx;       // expansion word index
  logic [RK_AW-1:0] ridx;       // round-key read index
  logic [31:0]      hist [8];   // last Nk words, hist[0] newest
  logic [2:0]       pos;        // i mod Nk
  logic [7:0]       rcon;
  logic [1:0]       col;
  logic             rd_pend;    // read issued last cycle
  logic [1:0]       rd_col;
  logic [3:0]       round, nr;
  logic [127:0]     st, acc;
  logic [127:0]     out_reg;
  logic             out_valid;

  logic [1:0]  code;
  logic [3:0]  nk;
  logic [5:0]  total;
  assign code  = (key_length == 2'd3) ? 2'd2 : key_length;
  assign nk    = 4'd4 + {1'b0, code, 1'b0};
  assign total = 6'd4 * ({2'b0, nk} + 6'd7);

  // expansion word
  logic [31:0] prev, far, tmp, new_word;
  assign prev = hist[0];
  assign far  = hist[3'(nk - 4'd1)];
  always_comb begin
    tmp = prev;
    if (pos == 3'd0) begin
      tmp = sub_word({prev[23:0], prev[31:24]}) ^ {rcon, 24'h0};
    end else if (nk > 4'd6 && pos == 3'd4) begin
      tmp = sub_word(prev);
    end
  end
  always_comb begin
    if (widx < RK_AW'(nk)) begin
      case (widx[2:0])
        3'd0: new_word = key_a[63:32];
        3'd1: new_word = key_a[31:0];
        3'd2: new_word = key_b[63:32];
        3'd3: new_word = key_b[31:0];
        3'd4: new_word = key_c[63:32];
        3'd5: new_word = key_c[31:0];
        3'd6: new_word = key_d[63:32];
        default: new_word = key_d[31:0];
      endcase
    end else begin
      new_word = far ^ tmp;
    end
  end

  // words past the store depth are dropped on write and read back as zero
  logic             ram_we;
  logic [31:0]      rk, rk_word;
  logic             raddr_oob;
  logic             rk_zero;
  logic [RK_AW-1:0] rk_raddr;
  assign ram_we    = (state == ST_EXPAND) && (widx < RK_AW'(RK_DEPTH));
  assign raddr_oob = (ridx >= RK_AW'(RK_DEPTH));
  assign rk_raddr  = raddr_oob ? '0 : ridx;
  assign rk_word   = rk_zero ? 32'h0 : rk;

  aes_ram #(.WIDTH(32), .DEPTH(RK_DEPTH)) u_rk (
    .clk(clk), .we(ram_we), .waddr(widx), .wdata(new_word),
    .raddr(rk_raddr), .rdata(rk)
  );

  // round function: SubBytes, ShiftRows, optional MixColumns; byte 0 = MSB
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int i = 0; i < 16; i++) t[i] = sbox(b[4*(((i>>2)+(i&3))&3)+(i&3)]);
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    return r;
  endfunction

  logic s_fire, m_fire, cfg_fire;
  assign cfg_ready = (state == ST_IDLE) && !out_valid;
  assign s_tready  = (state == ST_IDLE) && !out_valid && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s_fire    = s_tvalid && s_tready;
  assign m_fire    = m_tvalid && m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_reg;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cfg_fire) state_next = ST_EXPAND;
        else if (s_fire) state_next = ST_INIT;
      end
      ST_EXPAND: if (widx == RK_AW'(total - 6'd1)) state_next = ST_IDLE;
      ST_INIT:   state_next = ST_ROUND;
      ST_ROUND:  if (rd_pend && rd_col == 2'd3 && round == nr) state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // register file and control
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      key_a <= '0; key_b <= '0; key_c <= '0; key_d <= '0;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_KEY_LENGTH: key_length <= cfg_data[1:0];
          REG_KEY_WORD_A: key_a <= cfg_data;
          REG_KEY_WORD_B: key_b <= cfg_data;
          REG_KEY_WORD_C: key_c <= cfg_data;
          REG_KEY_WORD_D: key_d <= cfg_data;
          default: ;
        endcase
      end
      if (m_fire) out_valid <= 1'b0;
      if (state == ST_OUT) out_valid <= 1'b1;
      rd_pend <= (state == ST_INIT) || (state == ST_ROUND && !(rd_pend && rd_col == 2'd3
                 && round == nr));
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        widx <= '0; pos <= '0; rcon <= RCON_FIRST;
        ridx <= '0; col <= '0; round <= '0;
        nr <= 4'd10 + {1'b0, code, 1'b0};
        if (s_fire) st <= {s_tdata[63:0], s_tdata[127:64]};
      end
      ST_EXPAND: begin
        widx <= widx + 1'b1;
        for (int k = 7; k > 0; k--) hist[k] <= hist[k-1];
        hist[0] <= new_word;
        if (widx >= RK_AW'(nk)) begin
          if (pos == 3'd0) rcon <= xtime(rcon);
        end
        pos <= (pos == 3'(nk - 4'd1)) ? 3'd0 : pos + 3'd1;
      end
      ST_INIT: begin
        ridx <= ridx + 1'b1;
        col <= col + 2'd1;
        acc <= st;
      end
      ST_ROUND: begin
        if (!(rd_pend && rd_col == 2'd3) || round != nr) begin
          ridx <= ridx + 1'b1;
          col <= col + 2'd1;
        end
        if (rd_pend && rd_col == 2'd0 && round != 4'd0) begin
          // start of a round: apply round function to previous result
          acc <= round_fn(acc, round == nr) ^ {rk_word, 96'h0};
        end else if (rd_pend) begin
          // add one key word into its column
          acc[127-32*rd_col -: 32] <= acc[127-32*rd_col -: 32] ^ rk_word;
        end
        if (rd_pend && rd_col == 2'd3 && round != nr) begin
          round <= round + 4'd1;
        end
      end
      ST_OUT: begin
        out_reg <= {acc[63:0], acc[127:64]};
      end
      default: ;
    endcase
    rd_col <= col;
    rk_zero <= raddr_oob;
  end

`ifndef NO_ASSERTIONS
  a_out_after_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |=> m_tvalid) else $error("result not presented");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("accept while result pending");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AES-128/192/256 ECB block encryptor. Keys are
// loaded through the register channel between phases. Every plaintext block
// is encrypted by a behavioral AES model in the bench, and the ciphertext
// that comes back is checked in order. Both stream sides idle in random
// bursts, except in the last random phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aes_pkg::*;

  localparam int ROUNDS_LONGEST = 14;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic [63:0] lo_half;
    logic [63:0] hi_half;
  } block_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;

  aes_block_encrypt i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  // bench copy of key registers and expanded schedule
  logic [1:0]  key_size_reg;
  logic [63:0] key_regs [4];
  logic [31:0] sched [60];

  block_t      plain_q [$];
  block_t      cipher_q [$];
  int          errors = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int          sink_hold = 0;
  int          src_burst = 0;
  bit          in_taken = 1'b0;

  // byte substitution table
  logic [7:0] sb [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gmul2(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] subst_word(logic [31:0] w);
    return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
  endfunction

  // key schedule from the current register copy; size code 3 acts as 256
  function automatic void build_schedule();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    int          nk, total;
    nk = (key_size_reg == 2'd0) ? 4 : (key_size_reg == 2'd1) ? 6 : 8;
    total = 4 * (nk + 7);
    rc = RCON_FIRST;
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = key_regs[i][63:32];
      w[2*i+1] = key_regs[i][31:0];
    end
    for (int i = nk; i < total; i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gmul2(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = subst_word(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int i = 0; i < total; i++) sched[i] = w[i];
  endfunction

  // full encryption of one block; state bytes column-major
  function automatic block_t encrypt_block(block_t p);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [31:0] k;
    logic [127:0] flat;
    int nr;
    block_t res;
    nr = (key_size_reg == 2'd0) ? 10 : (key_size_reg == 2'd1) ? 12 : 14;
    flat = {p.hi_half, p.lo_half};
    for (int i = 0; i < 16; i++) st[i] = flat[127-8*i -: 8];
    for (int rnd = 0; rnd <= nr; rnd++) begin
      if (rnd > 0) begin
        for (int i = 0; i < 16; i++)
          tmp[i] = sb[st[4*(((i>>2) + (i&3)) & 3) + (i&3)]];
        st = tmp;
        if (rnd < nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            x = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
            st[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
            st[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
            st[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        k = sched[rnd*4 + c];
        for (int b = 0; b < 4; b++) st[4*c+b] ^= k[31-8*b -: 8];
      end
    end
    for (int i = 0; i < 16; i++) flat[127-8*i -: 8] = st[i];
    res.hi_half = flat[127:64];
    res.lo_half = flat[63:0];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly random bits, sometimes all-zero / all-one / single bit
  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  // input transaction seen at the rising edge
  always @(posedge clk) begin
    in_taken <= s_tvalid && s_tready;
  end

  // source driver: offers queued blocks at the falling edge
  always @(negedge clk) begin
    block_t b;
    if (!rst) begin
      if (in_taken) begin
        b = plain_q.pop_front();
        cipher_q.push_back(encrypt_block(b));
      end
      if (in_taken || !s_tvalid) begin
        if (src_burst > 0) begin
          src_burst <= src_burst - 1;
          s_tvalid  <= 1'b0;
        end else if (plain_q.size() > 0 && src_idle_en && $urandom_range(0, 7) == 0) begin
          src_burst <= $urandom_range(0, 4);
          s_tvalid  <= 1'b0;
        end else if (plain_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= plain_q[0];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink: random ready bursts plus forced long holds
  int sink_burst = 0;
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_tready  <= 1'b0;
    end else if (sink_burst > 0) begin
      sink_burst <= sink_burst - 1;
      m_tready   <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      sink_burst <= $urandom_range(0, 4);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ciphertext checker
  always @(posedge clk) begin
    block_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected ciphertext %h", $time, m_tdata);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (got.hi_half !== want.hi_half) begin
          $display("%0t: cipher_high expected %h actual %h", $time, want.hi_half, got.hi_half);
          errors++;
        end
        if (got.lo_half !== want.lo_half) begin
          $display("%0t: cipher_low expected %h actual %h", $time, want.lo_half, got.lo_half);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_KEY_LENGTH) key_size_reg = val[1:0];
    else key_regs[idx - 1] = val;
    build_schedule();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (plain_q.size() > 0 || s_tvalid || cipher_q.size() > 0) @(posedge clk);
    repeat (4 * (ROUNDS_LONGEST + 1) + 8) @(posedge clk);
  endtask

  task automatic load_key(input logic [1:0] sz, input logic [63:0] a, b, c, d);
    write_reg(REG_KEY_WORD_A, a);
    write_reg(REG_KEY_WORD_B, b);
    write_reg(REG_KEY_WORD_C, c);
    write_reg(REG_KEY_WORD_D, d);
    write_reg(REG_KEY_LENGTH, sz);
  endtask

  task automatic queue_block(input logic [63:0] hi, lo);
    block_t b;
    b.hi_half = hi;
    b.lo_half = lo;
    plain_q.push_back(b);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    key_size_reg = 2'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // standard vectors: 128, 192, 256 bit keys
    load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
    queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block('0, '0);
    queue_block('1, '1);
    queue_block(64'h8000000000000000, 64'h1);
    wait_drained();
    load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, '1);
    queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block('1, '0);
    wait_drained();
    load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block('0, '1);
    wait_drained();
    // unused size code behaves as 256, all-ones key
    load_key(2'd3, '1, '1, '1, '1);
    queue_block('0, '0);
    queue_block('1, '1);
    wait_drained();
    // all-zero key at 128 bits
    load_key(2'd0, '0, '0, '0, '0);
    queue_block('0, '0);
    wait_drained();

    // long sink hold while source keeps offering
    for (int i = 0; i < 8; i++) queue_block(pick64(), pick64());
    sink_hold = 400;
    wait_drained();

    // random phases, new key per phase
    for (int ph = 0; ph < 20; ph++) begin
      load_key(2'($urandom_range(0, 3)), pick64(), pick64(), pick64(), pick64());
      if (ph % 5 == 2) write_reg(REG_KEY_LENGTH, 2'($urandom_range(0, 2)));
      if (ph == 15) begin
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
      end
      for (int i = 0; i < 66; i++) queue_block(pick64(), pick64());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #12ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
